// ===== rtl/strm_pkg.sv =====
// shared constants and types for the sample timing and rssi monitor
package strm_pkg;

	// width of the expected interval register
	localparam int CFG_BITS = 32;
	// width of an rssi reading
	localparam int RSSI_BITS = 8;

	// event kind codes
	typedef enum logic {
		FUNC_SAMPLE = 1'b0,
		FUNC_ERROR  = 1'b1
	} func_t;

endpackage

// ===== rtl/sample_timing_rssi_monitor_unit.sv =====
// sample timing and rssi monitor with a bit-serial interval divider
//
// channel   dir  handshake                  payload
// sample    in   sample_valid/sample_ready  func, timestamp, rssi
// cfg       in   cfg_valid/cfg_ready        cfg_data (expected_interval)
// result    out  result_valid/result_ready  intervals, flags, counters
//
// an event that needs a miss division passes from beat to the next possible
// beat through one restoring divider step per cycle over the TIME_BITS
// interval bits, the saturating miss add and the load of the result register;
// any other event goes from the beat straight to the result register load.
// sample_ready is low while an event is in work; a result waiting in the output
// register holds the sequencer in its last state until the result beat.
// arst_n clears the monitor counters and flags and the expected interval.
module sample_timing_rssi_monitor_unit
	import strm_pkg::*;
#(
	parameter int TIME_BITS  = 48,
	parameter int COUNT_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// sample channel
	input  logic                        sample_valid,
	output logic                        sample_ready,
	input  logic                        func,
	input  logic [TIME_BITS-1:0]        timestamp,
	input  logic signed [RSSI_BITS-1:0] rssi,
	// configuration channel
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_BITS-1:0]         cfg_data,
	// result channel
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic signed [TIME_BITS:0]   query_interval,
	output logic signed [TIME_BITS:0]   change_interval,
	output logic signed [TIME_BITS:0]   unchanged_time,
	output logic                        success_flag,
	output logic                        level_changed,
	output logic [COUNT_BITS-1:0]       query_count,
	output logic [COUNT_BITS-1:0]       success_count,
	output logic [COUNT_BITS-1:0]       error_count,
	output logic [COUNT_BITS-1:0]       miss_count,
	output logic [COUNT_BITS-1:0]       change_count,
	output logic [COUNT_BITS-1:0]       repeat_count
);

	localparam int DIFF_W = TIME_BITS + 1;
	localparam int CNT_W  = $clog2(TIME_BITS + 1);
	localparam int SUM_W  = ((TIME_BITS > COUNT_BITS) ? TIME_BITS : COUNT_BITS) + 1;
	localparam logic [SUM_W-1:0] COUNT_TOP =
		{{(SUM_W-COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_MISS,
		ST_DONE
	} state_t;

	state_t state_q;

	// monitor state
	logic [CFG_BITS-1:0]        expected_q;
	logic                       have_query_q;
	logic [TIME_BITS-1:0]       last_query_q;
	logic                       have_level_q;
	logic [RSSI_BITS-1:0]       last_level_q;
	logic [TIME_BITS-1:0]       last_change_q;
	logic [COUNT_BITS-1:0]      queries_q;
	logic [COUNT_BITS-1:0]      successes_q;
	logic [COUNT_BITS-1:0]      errors_q;
	logic [COUNT_BITS-1:0]      misses_q;
	logic [COUNT_BITS-1:0]      changes_q;
	logic [COUNT_BITS-1:0]      repeats_q;

	// per-event result staging
	logic [DIFF_W-1:0]          q_int_q;
	logic [DIFF_W-1:0]          c_int_q;
	logic [DIFF_W-1:0]          unch_q;
	logic                       ok_q;
	logic                       changed_q;

	// divider registers: dividend shifts out, quotient shifts in
	logic [TIME_BITS-1:0]       dvd_q;
	logic [CFG_BITS-1:0]        rem_q;
	logic [CNT_W-1:0]           div_cnt_q;

	// result register
	logic                       res_valid_q;
	logic [DIFF_W-1:0]          res_q_int_q;
	logic [DIFF_W-1:0]          res_c_int_q;
	logic [DIFF_W-1:0]          res_unch_q;
	logic                       res_ok_q;
	logic                       res_changed_q;
	logic [COUNT_BITS-1:0]      res_queries_q;
	logic [COUNT_BITS-1:0]      res_successes_q;
	logic [COUNT_BITS-1:0]      res_errors_q;
	logic [COUNT_BITS-1:0]      res_misses_q;
	logic [COUNT_BITS-1:0]      res_changes_q;
	logic [COUNT_BITS-1:0]      res_repeats_q;

	logic                       sample_beat;
	logic                       out_free;
	logic [DIFF_W-1:0]          query_diff;
	logic [DIFF_W-1:0]          level_diff;
	logic                       level_differs;
	logic                       need_div;
	logic [CFG_BITS:0]          trial;
	logic [CFG_BITS:0]          trial_sub;
	logic                       q_bit;
	logic [SUM_W-1:0]           miss_sum;

	assign sample_ready = (state_q == ST_IDLE);
	assign cfg_ready    = 1'b1;
	assign sample_beat  = sample_valid && sample_ready;
	assign out_free     = !res_valid_q || result_ready;

	// interval arithmetic at the sample beat
	always_comb begin
		query_diff    = {1'b0, timestamp} - {1'b0, last_query_q};
		level_diff    = {1'b0, timestamp} - {1'b0, last_change_q};
		level_differs = (rssi != last_level_q);
		need_div      = have_query_q && !query_diff[TIME_BITS] && (query_diff != '0)
			&& (expected_q != '0);
	end

	// restoring divider step
	always_comb begin
		trial     = {rem_q, dvd_q[TIME_BITS-1]};
		trial_sub = trial - {1'b0, expected_q};
		q_bit     = !trial_sub[CFG_BITS];
	end

	// saturating miss add of quotient minus one
	always_comb begin
		miss_sum = {{(SUM_W-COUNT_BITS){1'b0}}, misses_q}
			+ {{(SUM_W-TIME_BITS){1'b0}}, dvd_q} - {{(SUM_W-1){1'b0}}, 1'b1};
	end

	// sequencer, monitor state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			expected_q   <= '0;
			have_query_q <= 1'b0;
			last_query_q <= '0;
			have_level_q <= 1'b0;
			last_level_q <= '0;
			last_change_q <= '0;
			queries_q    <= '0;
			successes_q  <= '0;
			errors_q     <= '0;
			misses_q     <= '0;
			changes_q    <= '0;
			repeats_q    <= '0;
			div_cnt_q    <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				expected_q <= cfg_data;
			end
			// a result beat empties the register unless a new result loads now
			if (result_valid && result_ready && (state_q != ST_DONE)) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (sample_beat) begin
						// query bookkeeping
						if (queries_q != '1) queries_q <= queries_q + 1'b1;
						q_int_q      <= have_query_q ? query_diff : '1;
						have_query_q <= 1'b1;
						last_query_q <= timestamp;
						// error count for an error, rssi tracking for a successful sample
						if (func == FUNC_ERROR) begin
							c_int_q   <= '1;
							unch_q    <= '1;
							ok_q      <= 1'b0;
							changed_q <= 1'b0;
							if (errors_q != '1) errors_q <= errors_q + 1'b1;
						end else begin
							ok_q <= 1'b1;
							if (successes_q != '1) successes_q <= successes_q + 1'b1;
							if (!have_level_q) begin
								have_level_q  <= 1'b1;
								last_level_q  <= rssi;
								last_change_q <= timestamp;
								c_int_q       <= '1;
								unch_q        <= '0;
								changed_q     <= 1'b0;
							end else if (level_differs) begin
								changed_q     <= 1'b1;
								c_int_q       <= level_diff;
								unch_q        <= '0;
								last_level_q  <= rssi;
								last_change_q <= timestamp;
								if (changes_q != '1) changes_q <= changes_q + 1'b1;
							end else begin
								changed_q <= 1'b0;
								c_int_q   <= '1;
								unch_q    <= level_diff;
								if (repeats_q != '1) repeats_q <= repeats_q + 1'b1;
							end
						end
						// start the divider when a miss count may follow
						if (need_div) begin
							dvd_q     <= query_diff[TIME_BITS-1:0];
							rem_q     <= '0;
							div_cnt_q <= CNT_W'(TIME_BITS);
							state_q   <= ST_DIV;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DIV: begin
					rem_q     <= q_bit ? trial_sub[CFG_BITS-1:0] : trial[CFG_BITS-1:0];
					dvd_q     <= {dvd_q[TIME_BITS-2:0], q_bit};
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == CNT_W'(1)) begin
						state_q <= ST_MISS;
					end
				end
				ST_MISS: begin
					// quotient above one adds missed slots
					if (dvd_q > TIME_BITS'(1)) begin
						misses_q <= (miss_sum > COUNT_TOP) ? '1 : miss_sum[COUNT_BITS-1:0];
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						res_valid_q     <= 1'b1;
						res_q_int_q     <= q_int_q;
						res_c_int_q     <= c_int_q;
						res_unch_q      <= unch_q;
						res_ok_q        <= ok_q;
						res_changed_q   <= changed_q;
						res_queries_q   <= queries_q;
						res_successes_q <= successes_q;
						res_errors_q    <= errors_q;
						res_misses_q    <= misses_q;
						res_changes_q   <= changes_q;
						res_repeats_q   <= repeats_q;
						state_q         <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result port drive
	assign result_valid    = res_valid_q;
	assign query_interval  = res_q_int_q;
	assign change_interval = res_c_int_q;
	assign unchanged_time  = res_unch_q;
	assign success_flag    = res_ok_q;
	assign level_changed   = res_changed_q;
	assign query_count     = res_queries_q;
	assign success_count   = res_successes_q;
	assign error_count     = res_errors_q;
	assign miss_count      = res_misses_q;
	assign change_count    = res_changes_q;
	assign repeat_count    = res_repeats_q;

	// a sample beat always starts work
	a_beat_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		sample_beat |=> (state_q != ST_IDLE))
		else $error("sequencer stayed idle after a sample beat");

	// the divider never runs with an exhausted step count
	a_div_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (div_cnt_q != '0))
		else $error("divider running with zero steps left");

	// the miss count only grows
	a_miss_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (misses_q >= $past(misses_q)))
		else $error("miss count went down");

	// every success and every error is also a query
	a_counts_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(successes_q <= queries_q) && (errors_q <= queries_q))
		else $error("success or error count above query count");

endmodule

// ===== sim/tb_top.sv =====
// self-checking testbench for the sample timing and rssi monitor unit
module tb_top;
	import strm_pkg::*;

	localparam int TB = 48;
	localparam int CB = 32;
	localparam logic [TB:0]   NEG1 = {(TB+1){1'b1}};
	localparam logic [TB-1:0] MAXT = {TB{1'b1}};
	localparam logic [CB-1:0] CMAX = {CB{1'b1}};
	// random events per interval setting
	localparam int PHASE_EVENTS = 165;
	// drain time after the last result, a little over one divider pass
	localparam int TAIL_CYCLES = TB + 12;

	// one predicted result beat
	typedef struct packed {
		logic [TB:0]   q_int;
		logic [TB:0]   c_int;
		logic [TB:0]   still;
		logic          ok;
		logic          changed;
		logic [CB-1:0] queries;
		logic [CB-1:0] successes;
		logic [CB-1:0] errors;
		logic [CB-1:0] misses;
		logic [CB-1:0] changes;
		logic [CB-1:0] repeats;
	} report_t;

	// one directed event, with the hand-typed result where it is obvious
	typedef struct packed {
		func_t         kind;
		logic [TB-1:0] ts;
		logic [7:0]    level;
		logic          typed;
		logic [TB:0]   q_int;
		logic [TB:0]   c_int;
		logic [TB:0]   still;
		logic          ok;
		logic          changed;
	} plan_row_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  sample_valid = 1'b0;
	logic                  sample_ready;
	logic                  func = 1'b0;
	logic [TB-1:0]         timestamp = '0;
	logic signed [7:0]     rssi = '0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_BITS-1:0]   cfg_data = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	logic signed [TB:0]    query_interval;
	logic signed [TB:0]    change_interval;
	logic signed [TB:0]    unchanged_time;
	logic                  success_flag;
	logic                  level_changed;
	logic [CB-1:0]         query_count;
	logic [CB-1:0]         success_count;
	logic [CB-1:0]         error_count;
	logic [CB-1:0]         miss_count;
	logic [CB-1:0]         change_count;
	logic [CB-1:0]         repeat_count;

	sample_timing_rssi_monitor_unit #(
		.TIME_BITS (TB),
		.COUNT_BITS(CB)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.sample_ready   (sample_ready),
		.func           (func),
		.timestamp      (timestamp),
		.rssi           (rssi),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.query_interval (query_interval),
		.change_interval(change_interval),
		.unchanged_time (unchanged_time),
		.success_flag   (success_flag),
		.level_changed  (level_changed),
		.query_count    (query_count),
		.success_count  (success_count),
		.error_count    (error_count),
		.miss_count     (miss_count),
		.change_count   (change_count),
		.repeat_count   (repeat_count)
	);

	// directed events: reset state, then interval 1000, then all ones, then miss saturation
	plan_row_t plan [0:20] = '{
		'{FUNC_ERROR,  48'd0,  8'd0,     1'b1, NEG1,        NEG1,   NEG1,   1'b0, 1'b0},
		'{FUNC_SAMPLE, 48'd10, -8'sd50,  1'b1, 49'd10,      NEG1,   49'd0,  1'b1, 1'b0},
		'{FUNC_SAMPLE, 48'd25, -8'sd50,  1'b1, 49'd15,      NEG1,   49'd15, 1'b1, 1'b0},
		'{FUNC_SAMPLE, 48'd40, 8'sd127,  1'b1, 49'd15,      49'd30, 49'd0,  1'b1, 1'b1},
		'{FUNC_SAMPLE, 48'd40, -8'sd128, 1'b1, 49'd0,       49'd0,  49'd0,  1'b1, 1'b1},
		'{FUNC_ERROR,  48'd0,  8'sd127,  1'b1, -49'sd40,    NEG1,   NEG1,   1'b0, 1'b0},
		'{FUNC_SAMPLE, MAXT,   -8'sd128, 1'b0, '0, '0, '0, 1'b0, 1'b0},
		'{FUNC_SAMPLE, 48'd0,  8'd0,     1'b0, '0, '0, '0, 1'b0, 1'b0},
		'{FUNC_ERROR,  MAXT,   -8'sd1,   1'b0, '0, '0, '0, 1'b0, 1'b0},
		'{FUNC_SAMPLE, 48'd1000,  8'd0,  1'b0, '0, '0, '0, 1'b0, 1'b0},
		'{FUNC_SAMPLE, 48'd2000,  8'd0,  1'b0, '0, '0, '0, 1'b0, 1'b0},
		'{FUNC_SAMPLE, 48'd3999,  8'd0,  1'b0, '0, '0, '0, 1'b0, 1'b0},
		'{FUNC_ERROR,  48'd6000,  8'd0,  1'b0, '0, '0, '0, 1'b0, 1'b0},
		'{FUNC_SAMPLE, 48'd16000, 8'd5,  1'b0, '0, '0, '0, 1'b0, 1'b0},
		'{FUNC_SAMPLE, 48'd16000, 8'd5,  1'b0, '0, '0, '0, 1'b0, 1'b0},
		'{FUNC_SAMPLE, 48'd12884917885, 8'd5, 1'b0, '0, '0, '0, 1'b0, 1'b0},
		'{FUNC_ERROR,  MAXT,   8'd5,     1'b0, '0, '0, '0, 1'b0, 1'b0},
		'{FUNC_SAMPLE, 48'd0,  -8'sd128, 1'b0, '0, '0, '0, 1'b0, 1'b0},
		'{FUNC_SAMPLE, MAXT,   8'sd127,  1'b0, '0, '0, '0, 1'b0, 1'b0},
		'{FUNC_ERROR,  48'd0,  8'sd127,  1'b0, '0, '0, '0, 1'b0, 1'b0},
		'{FUNC_SAMPLE, 48'h0001_0000_0000, 8'sd127, 1'b0, '0, '0, '0, 1'b0, 1'b0}
	};

	// monitor model state
	logic [CFG_BITS-1:0] m_expected = '0;
	logic                m_have_query = 1'b0;
	logic [TB-1:0]       m_last_query = '0;
	logic                m_have_level = 1'b0;
	logic [7:0]          m_last_level = '0;
	logic [TB-1:0]       m_last_change = '0;
	logic [CB-1:0]       m_queries = '0;
	logic [CB-1:0]       m_successes = '0;
	logic [CB-1:0]       m_errors = '0;
	logic [CB-1:0]       m_misses = '0;
	logic [CB-1:0]       m_changes = '0;
	logic [CB-1:0]       m_repeats = '0;

	report_t pending_reports [$];
	report_t front_report;
	int      mismatches = 0;
	int      settings_used = 0;
	bit      offering = 1'b0;

	// stimulus generator memory
	logic [TB-1:0] gen_ts = '0;
	logic [7:0]    gen_level = '0;

	// idling knobs and the receiver hold-off
	int sender_idle_pct = 0;
	int recv_stall_pct = 0;
	int rx_cycle = 0;
	int hold_until = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// saturating counter add
	function automatic logic [CB-1:0] sat_add(logic [CB-1:0] a, logic [63:0] b);
		logic [CB-1:0] room;
		room = ~a;
		if (b > 64'(room))
			return CMAX;
		return a + b[CB-1:0];
	endfunction

	// next result beat for one sampling event, advancing the model state
	function automatic report_t predict_report(func_t kind, logic [TB-1:0] ts, logic [7:0] lv);
		report_t r;
		logic [63:0] slots;
		r = '0;
		r.q_int = NEG1;
		r.c_int = NEG1;
		r.still = NEG1;
		m_queries = sat_add(m_queries, 64'd1);
		// query interval and schedule misses
		if (m_have_query) begin
			r.q_int = {1'b0, ts} - {1'b0, m_last_query};
			if (ts > m_last_query && m_expected != '0) begin
				slots = 64'(ts - m_last_query) / 64'(m_expected);
				if (slots > 64'd1)
					m_misses = sat_add(m_misses, slots - 64'd1);
			end
		end
		m_last_query = ts;
		m_have_query = 1'b1;
		// rssi tracking on successes only
		if (kind == FUNC_ERROR) begin
			m_errors = sat_add(m_errors, 64'd1);
		end else begin
			r.ok = 1'b1;
			m_successes = sat_add(m_successes, 64'd1);
			if (!m_have_level) begin
				m_have_level = 1'b1;
				m_last_level = lv;
				m_last_change = ts;
				r.still = '0;
			end else if (lv != m_last_level) begin
				r.changed = 1'b1;
				r.c_int = {1'b0, ts} - {1'b0, m_last_change};
				r.still = '0;
				m_changes = sat_add(m_changes, 64'd1);
				m_last_level = lv;
				m_last_change = ts;
			end else begin
				m_repeats = sat_add(m_repeats, 64'd1);
				r.still = {1'b0, ts} - {1'b0, m_last_change};
			end
		end
		r.queries = m_queries;
		r.successes = m_successes;
		r.errors = m_errors;
		r.misses = m_misses;
		r.changes = m_changes;
		r.repeats = m_repeats;
		return r;
	endfunction

	// offer one event beat and wait until it is taken
	task automatic send_event(func_t kind, logic [TB-1:0] ts, logic [7:0] lv);
		if ($urandom_range(0, 99) < sender_idle_pct) begin
			if (offering)
				sample_valid <= 1'b0;
			offering = 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
		end
		sample_valid <= 1'b1;
		offering = 1'b1;
		func <= kind;
		timestamp <= ts;
		rssi <= lv;
		do @(posedge clk); while (!sample_ready);
		gen_ts = ts;
		gen_level = lv;
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain_results();
		if (offering)
			sample_valid <= 1'b0;
		offering = 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
	endtask

	// register write, only with the block idle
	task automatic set_expected(logic [CFG_BITS-1:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		m_expected = value;
		settings_used++;
	endtask

	task automatic set_idling(int mode);
		case (mode)
			0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin sender_idle_pct = 75; recv_stall_pct = 0;  end
			2: begin sender_idle_pct = 0;  recv_stall_pct = 75; end
			default: begin sender_idle_pct = 18; recv_stall_pct = 18; end
		endcase
	endtask

	// walk a slice of the directed table
	task automatic walk_plan(int lo, int hi);
		report_t r;
		for (int i = lo; i <= hi; i++) begin
			send_event(plan[i].kind, plan[i].ts, plan[i].level);
			r = predict_report(plan[i].kind, plan[i].ts, plan[i].level);
			if (plan[i].typed) begin
				r.q_int = plan[i].q_int;
				r.c_int = plan[i].c_int;
				r.still = plan[i].still;
				r.ok = plan[i].ok;
				r.changed = plan[i].changed;
			end
			pending_reports.push_back(r);
		end
	endtask

	// one random event, mostly on or near the schedule grid
	task automatic random_event();
		func_t         kind;
		logic [TB-1:0] ts;
		logic [7:0]    lv;
		logic [63:0]   step;
		int            r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			if (m_expected == '0)
				step = 64'($urandom_range(0, 5000));
			else
				step = 64'(m_expected) * $urandom_range(0, 4) + $urandom_range(0, 2) - 64'd1;
			ts = gen_ts + step[TB-1:0];
		end else if (r < 75) begin
			ts = gen_ts + TB'($urandom_range(0, 65535));
		end else if (r < 85) begin
			ts = gen_ts - TB'($urandom_range(1, 100000));
		end else if (r < 92) begin
			ts = gen_ts;
		end else if (m_expected == '0 || m_expected >= 32'h0100_0000) begin
			// whole range jumps, kept off small intervals so misses stay short of full
			ts = {16'($urandom), 32'($urandom)};
		end else begin
			ts = gen_ts + TB'($urandom_range(0, 1 << 20));
		end
		r = $urandom_range(0, 99);
		if (r < 50)
			lv = gen_level;
		else if (r < 80)
			lv = gen_level + 8'($urandom_range(0, 2)) - 8'd1;
		else
			lv = 8'($urandom);
		kind = ($urandom_range(0, 5) == 0) ? FUNC_ERROR : FUNC_SAMPLE;
		send_event(kind, ts, lv);
		pending_reports.push_back(predict_report(kind, ts, lv));
	endtask

	task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %s: expected %h, got %h", name, want, got);
		end
	endtask

	// receiver: random stalls plus a counted hold-off
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (rx_cycle < hold_until)
			result_ready <= 1'b0;
		else
			result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// result beat checker
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (pending_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result beat with no event outstanding");
			end else begin
				front_report = pending_reports.pop_front();
				compare_field("query_interval", {15'b0, front_report.q_int},
					{15'b0, query_interval});
				compare_field("change_interval", {15'b0, front_report.c_int},
					{15'b0, change_interval});
				compare_field("unchanged_time", {15'b0, front_report.still},
					{15'b0, unchanged_time});
				compare_field("success_flag", 64'(front_report.ok), 64'(success_flag));
				compare_field("level_changed", 64'(front_report.changed),
					64'(level_changed));
				compare_field("query_count", 64'(front_report.queries), 64'(query_count));
				compare_field("success_count", 64'(front_report.successes),
					64'(success_count));
				compare_field("error_count", 64'(front_report.errors), 64'(error_count));
				compare_field("miss_count", 64'(front_report.misses), 64'(miss_count));
				compare_field("change_count", 64'(front_report.changes), 64'(change_count));
				compare_field("repeat_count", 64'(front_report.repeats), 64'(repeat_count));
			end
		end
	end

	// main sequence
	initial begin : stimulus
		logic [CFG_BITS-1:0] interval;
		int                  failures;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset value of the interval first, then a mid value and all ones
		set_idling(0);
		walk_plan(0, 8);
		set_expected(32'd1000);
		walk_plan(9, 14);
		set_expected(CMAX);
		walk_plan(15, 16);

		// random phases, one interval setting and one idling mode each
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: interval = '0;
				1: interval = 32'd1;
				2: interval = 32'd37;
				3: interval = CMAX;
				4: interval = 32'($urandom_range(2, 5000));
				5: interval = 32'd1000;
				6: interval = 32'($urandom);
				default: interval = '0;
			endcase
			set_expected(interval);
			set_idling(p % 4);
			// long receiver hold-off while the sender keeps offering
			if (p == 4)
				hold_until = rx_cycle + 400;
			for (int n = 0; n < PHASE_EVENTS; n++) begin
				if (p == 5 && n == PHASE_EVENTS / 2)
					drain_results();
				random_event();
			end
		end

		// miss counter saturation last, since it never comes back down
		set_idling(3);
		set_expected(32'd1);
		walk_plan(17, 20);

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		failures = mismatches + pending_reports.size();
		if (pending_reports.size() != 0)
			$display("%0d results never arrived", pending_reports.size());
		$display("covered %0d events over %0d interval settings under four idling modes",
			m_queries, settings_used);
		$display("model saw %0d read errors, %0d rssi changes, %0d repeats, miss count %h",
			m_errors, m_changes, m_repeats, m_misses);
		if (failures == 0)
			$display("PASS sample_timing_rssi_monitor_unit");
		else
			$display("FAIL sample_timing_rssi_monitor_unit");
		$finish;
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("timeout with %0d results outstanding", pending_reports.size());
		$display("FAIL sample_timing_rssi_monitor_unit");
		$finish;
	end

endmodule
